>>> design/btpm_pkg.sv
// Package for the binary trie prefix matcher: sizes, codes and the trie node type.
// Used by the channel interfaces, the node store and the top level.
package btpm_pkg;

  localparam int unsigned NODE_COUNT = 4096;
  localparam int unsigned ADDR_BITS  = 32;
  localparam int unsigned NODE_IDX_W = $clog2(NODE_COUNT);
  localparam int unsigned CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int unsigned LEVEL_W    = $clog2(ADDR_BITS + 1);
  localparam int unsigned PLEN_W     = 6;

  // Operation codes of an input item.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Status codes of a result item.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [NODE_IDX_W-1:0] node_idx_t;

  // One trie node: two child indexes (zero means none) and the subnet mark.
  typedef struct packed {
    logic      subnet;
    node_idx_t kid1;
    node_idx_t kid0;
  } node_t;

  // Write request from the walk sequencer to the node store.
  typedef struct packed {
    logic      en;
    node_idx_t idx;
    node_t     node;
  } node_wr_t;

endpackage

>>> design/btpm_if.sv
// Valid/ready channel interfaces for the binary trie prefix matcher.
// Depends on btpm_pkg for the field widths.
interface btpm_in_if
  import btpm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [ADDR_BITS-1:0] address;
  logic [PLEN_W-1:0]    prefix_len;

  modport source (output valid, output op, output address, output prefix_len, input ready);
  modport sink   (input valid, input op, input address, input prefix_len, output ready);
endinterface

interface btpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic status;

  modport source (output valid, output matched, output status, input ready);
  modport sink   (input valid, input matched, input status, output ready);
endinterface

>>> design/btpm_node_store.sv
// Trie node storage: the root node in flip-flops and the other nodes in a memory.
// Depends on btpm_pkg for the node type and sizes.
module btpm_node_store
  import btpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  node_idx_t rd_idx_i,
  input  node_wr_t  wr_i,
  output node_t     rd_node_o
);

  node_t     mem_q [NODE_COUNT];
  node_t     mem_rdata_q;
  node_t     root_q;
  logic      rd_root_q;

  // The root is cleared by reset and is always read from its own register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q    <= '0;
      rd_root_q <= 1'b1;
    end else begin
      rd_root_q <= (rd_idx_i == '0);
      if (wr_i.en && (wr_i.idx == '0)) begin
        root_q <= wr_i.node;
      end
    end
  end

  // Node memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx != '0)) begin
      mem_q[wr_i.idx] <= wr_i.node;
    end
    mem_rdata_q <= mem_q[rd_idx_i];
  end

  assign rd_node_o = rd_root_q ? root_q : mem_rdata_q;

endmodule

>>> design/binary_trie_prefix_match.sv
// Binary trie prefix matcher over 32-bit addresses, most significant bit first. An insert
// walks from the root, allocating missing nodes in order from the 4095 store entries after the
// root, and marks the node reached as a subnet when the prefix length is below 32 (lengths
// above 32 count as 32); status reads 1 when the store ran out of free nodes. A lookup matches
// on meeting a subnet node or on completing all 32 levels. The walk goes down one trie level
// per cycle, paced by the single read port of the node memory. The result is registered at
// the edge that ends the walk. One item is in work at a time; the next can be accepted while
// the previous result still waits in the output register, and a walk only holds at its last
// level while that register is still full. No clearing pass is needed after reset.
module binary_trie_prefix_match
  import btpm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  btpm_in_if.sink    in_i,
  btpm_out_if.source out_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                 state_q, state_d;
  logic                 op_q;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [LEVEL_W-1:0]   plen_q;
  logic [LEVEL_W-1:0]   level_q, level_d;
  node_idx_t            cur_q, cur_d;
  logic                 fresh_q, fresh_d;
  logic [CNT_W-1:0]     next_free_q, next_free_d;
  logic                 out_valid_q;
  logic                 matched_q;
  logic                 status_q;

  node_t     rd_node;
  node_t     content;
  node_idx_t rd_idx;
  node_idx_t child;
  node_wr_t  wr_req;
  node_wr_t  wr;
  logic      addr_bit;
  logic      has_child;
  logic      pool_full;
  logic      done;
  logic      adv;
  logic      alloc;
  logic      res_matched;
  logic      res_status;
  logic      step;
  logic      in_xfer;
  logic [LEVEL_W-1:0] plen_clamped;

  btpm_node_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (rd_idx),
    .wr_i      (wr),
    .rd_node_o (rd_node)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  // Lengths above the address width count as a full address.
  assign plen_clamped = (in_i.prefix_len > PLEN_W'(ADDR_BITS))
                      ? LEVEL_W'(ADDR_BITS) : LEVEL_W'(in_i.prefix_len);

  // A freshly allocated node is empty and is not read back from the store.
  assign content   = fresh_q ? '0 : rd_node;
  assign addr_bit  = addr_q[ADDR_BITS-1];
  assign child     = addr_bit ? content.kid1 : content.kid0;
  assign has_child = (child != '0);
  assign pool_full = (next_free_q == CNT_W'(NODE_COUNT));

  // Decision for the current level of the walk.
  always_comb begin
    done        = 1'b0;
    adv         = 1'b0;
    alloc       = 1'b0;
    res_matched = 1'b0;
    res_status  = STATUS_OK;
    wr_req.en   = 1'b0;
    wr_req.idx  = cur_q;
    wr_req.node = content;
    if (op_q == OP_LOOKUP) begin
      priority if (content.subnet) begin
        done        = 1'b1;
        res_matched = 1'b1;
      end else if (!has_child) begin
        done = 1'b1;
      end else if (level_q == LEVEL_W'(ADDR_BITS - 1)) begin
        done        = 1'b1;
        res_matched = 1'b1;
      end else begin
        adv = 1'b1;
      end
    end else begin
      priority if (level_q == plen_q) begin
        done = 1'b1;
        if (plen_q != LEVEL_W'(ADDR_BITS)) begin
          wr_req.en          = 1'b1;
          wr_req.node.subnet = 1'b1;
        end else begin
          wr_req.en = fresh_q;
        end
      end else if (has_child) begin
        adv = 1'b1;
      end else if (pool_full) begin
        // A fresh node has to be written empty so that its parent link stays sound.
        done       = 1'b1;
        res_status = STATUS_FULL;
        wr_req.en  = fresh_q;
      end else begin
        alloc     = 1'b1;
        wr_req.en = 1'b1;
        if (addr_bit) begin
          wr_req.node.kid1 = next_free_q[NODE_IDX_W-1:0];
        end else begin
          wr_req.node.kid0 = next_free_q[NODE_IDX_W-1:0];
        end
      end
    end
  end

  // The final step waits while the output register still holds an untaken result.
  assign step = (state_q == ST_WALK) && (!done || !out_valid_q || out_o.ready);

  always_comb begin
    wr     = wr_req;
    wr.en  = wr_req.en && step;
  end

  // Read address: root while idle, the child on a step down, otherwise the current node.
  always_comb begin
    if (state_q == ST_IDLE) begin
      rd_idx = '0;
    end else if (step && adv) begin
      rd_idx = child;
    end else begin
      rd_idx = cur_q;
    end
  end

  // Next state of the walk sequencer.
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    level_d     = level_q;
    cur_d       = cur_q;
    fresh_d     = fresh_q;
    next_free_d = next_free_q;
    if (state_q == ST_IDLE) begin
      if (in_xfer) begin
        state_d = ST_WALK;
        addr_d  = in_i.address;
        level_d = '0;
        cur_d   = '0;
        fresh_d = 1'b0;
      end
    end else if (step) begin
      if (done) begin
        state_d = ST_IDLE;
      end else begin
        addr_d  = {addr_q[ADDR_BITS-2:0], 1'b0};
        level_d = level_q + LEVEL_W'(1);
        if (alloc) begin
          cur_d       = next_free_q[NODE_IDX_W-1:0];
          fresh_d     = 1'b1;
          next_free_d = next_free_q + CNT_W'(1);
        end else begin
          cur_d   = child;
          fresh_d = 1'b0;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_free_q <= CNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      if (step && done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the item in progress and the result register.
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    level_q <= level_d;
    cur_q   <= cur_d;
    fresh_q <= fresh_d;
    if (in_xfer) begin
      op_q   <= in_i.op;
      plen_q <= plen_clamped;
    end
    if (step && done) begin
      matched_q <= res_matched;
      status_q  <= res_status;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.matched = matched_q;
  assign out_o.status  = status_q;

`ifndef SYNTH
  // The allocation pointer never passes the end of the pool.
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= CNT_W'(NODE_COUNT))
    else $error("node allocation pointer beyond pool");

  // Nodes are only allocated by a walking insert.
  a_alloc_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_free_q != $past(next_free_q))
      |-> ($past(state_q == ST_WALK) && $past(op_q == OP_INSERT)))
    else $error("node allocated outside an insert");

  // The walk never goes deeper than the address width.
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (level_q <= LEVEL_W'(ADDR_BITS)))
    else $error("walk level beyond address width");

  // A result appears only at the end of a walk.
  a_result_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q == ST_WALK) && (state_q == ST_IDLE)))
    else $error("result presented without a finished walk");

  // A lookup never stands on a freshly allocated node.
  a_fresh_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && fresh_q) |-> (op_q == OP_INSERT))
    else $error("fresh node seen by a lookup");
`endif

endmodule
